// ===== src/pcmcm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM channel map converter package
// Shared constants, types and sample codec functions.
// ----------------------------------------------------------------------------
package pcmcm_pkg;

   localparam int CHANNELS    = 8;
   localparam int MAP_ENTRIES = 4;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [3:0] FMT_S8    = 4'd0;
   localparam logic [3:0] FMT_U8    = 4'd1;
   localparam logic [3:0] FMT_S16LE = 4'd2;
   localparam logic [3:0] FMT_S16BE = 4'd3;
   localparam logic [3:0] FMT_U16LE = 4'd4;
   localparam logic [3:0] FMT_U16BE = 4'd5;
   localparam logic [3:0] FMT_S32LE = 4'd6;
   localparam logic [3:0] FMT_S32BE = 4'd7;
   localparam logic [3:0] FMT_U32LE = 4'd8;
   localparam logic [3:0] FMT_U32BE = 4'd9;
   localparam logic [3:0] FMT_ULAW  = 4'd10;
   localparam logic [3:0] FMT_ALAW  = 4'd11;

   localparam logic [2:0] REG_SRC_FMT = 3'd0;
   localparam logic [2:0] REG_DST_FMT = 3'd1;
   localparam logic [2:0] REG_COUNT   = 3'd2;
   localparam logic [2:0] REG_ENTRY_A = 3'd3;
   localparam logic [2:0] REG_ENTRY_B = 3'd4;
   localparam logic [2:0] REG_ENTRY_C = 3'd5;
   localparam logic [2:0] REG_ENTRY_D = 3'd6;

   localparam logic [1:0] OP_COPY    = 2'd0;
   localparam logic [1:0] OP_LITERAL = 2'd1;
   localparam logic [1:0] OP_ADD     = 2'd2;
   localparam logic [1:0] OP_ADDK    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       store;    // write the accepted sample into the frame store
      logic       fetch;    // read operands of the current entry
      logic       add;      // form the exact sum of the operands
      logic       compute;  // encode the sum into the result register
      logic [1:0] entry;    // entry being walked
      logic       last;     // this entry is the last of the walk
   } cmd_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic signed [32:0] ulaw_dec(input logic [7:0] code);
      logic [7:0]  u;
      logic [16:0] t;
      u = ~code;
      t = ({13'd0, u[3:0]} << 3) + 17'h84;
      t = t << u[6:4];
      ulaw_dec = u[7] ? 33'sd132 - $signed({16'd0, t}) : $signed({16'd0, t}) - 33'sd132;
   endfunction

   function automatic logic signed [32:0] alaw_dec(input logic [7:0] code);
      logic [7:0]  a;
      logic [16:0] t;
      a = code ^ 8'h55;
      t = {9'd0, a[3:0], 4'd0};
      if (a[6:4] == 3'd0) begin
         t = t + 17'd8;
      end else if (a[6:4] == 3'd1) begin
         t = t + 17'h108;
      end else begin
         t = (t + 17'h108) << (a[6:4] - 3'd1);
      end
      alaw_dec = a[7] ? $signed({16'd0, t}) : -$signed({16'd0, t});
   endfunction

   function automatic logic signed [32:0] decode(input logic [31:0] raw,
                                                 input logic [3:0] fmt);
      logic [31:0] sw;
      sw = swap32(raw);
      case (fmt)
         FMT_S8:    decode = 33'($signed(raw[7:0]));
         FMT_U8:    decode = {25'd0, raw[7:0]};
         FMT_S16LE: decode = 33'($signed(raw[15:0]));
         FMT_S16BE: decode = 33'($signed({raw[7:0], raw[15:8]}));
         FMT_U16LE: decode = {17'd0, raw[15:0]};
         FMT_U16BE: decode = {17'd0, raw[7:0], raw[15:8]};
         FMT_S32LE: decode = 33'($signed(raw));
         FMT_S32BE: decode = 33'($signed(sw));
         FMT_U32LE: decode = {1'b0, raw};
         FMT_U32BE: decode = {1'b0, sw};
         FMT_ULAW:  decode = ulaw_dec(raw[7:0]);
         FMT_ALAW:  decode = alaw_dec(raw[7:0]);
         default:   decode = '0;
      endcase
   endfunction

   // Segment search is a priority encode over eight thresholds.
   function automatic logic [7:0] ulaw_enc(input logic signed [15:0] s);
      logic signed [17:0] p;
      logic [7:0] mask;
      logic [3:0] seg;
      logic [13:0] pu;
      p = (18'(s) + 18'sd32768) >>> 2;
      p = p - 18'sd8192;
      mask = 8'hFF;
      if (p < 0) begin
         p = -p;
         mask = 8'h7F;
      end
      if (p > 18'sd8159) p = 18'sd8159;
      p = p + 18'sd33;
      pu = p[13:0];
      seg = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (pu <= 14'((64 << i) - 1)) seg = 4'(i);
      end
      if (seg[3]) ulaw_enc = 8'h7F ^ mask;
      else ulaw_enc = {1'b0, seg[2:0], 4'(pu >> (seg + 4'd1))} ^ mask;
   endfunction

   function automatic logic [7:0] alaw_enc(input logic signed [15:0] s);
      logic signed [17:0] p;
      logic [7:0] mask;
      logic [3:0] seg;
      logic [13:0] pu;
      logic [3:0] man;
      p = (18'(s) + 18'sd32768) >>> 3;
      p = p - 18'sd4096;
      mask = 8'hD5;
      if (p < 0) begin
         p = -p - 18'sd1;
         mask = 8'h55;
      end
      pu = p[13:0];
      seg = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (pu <= 14'((32 << i) - 1)) seg = 4'(i);
      end
      man = (seg < 4'd2) ? 4'(pu >> 1) : 4'(pu >> seg);
      if (seg[3]) alaw_enc = 8'h7F ^ mask;
      else alaw_enc = {1'b0, seg[2:0], man} ^ mask;
   endfunction

   function automatic logic [31:0] encode(input logic signed [33:0] v,
                                          input logic [3:0] fmt);
      logic signed [15:0] s;
      if (v > 34'sd32767) s = 16'sh7FFF;
      else if (v < -34'sd32768) s = 16'sh8000;
      else s = v[15:0];
      case (fmt)
         FMT_S8, FMT_U8:       encode = {24'd0, v[7:0]};
         FMT_S16LE, FMT_U16LE: encode = {16'd0, v[15:0]};
         FMT_S16BE, FMT_U16BE: encode = {16'd0, v[7:0], v[15:8]};
         FMT_S32LE, FMT_U32LE: encode = v[31:0];
         FMT_S32BE, FMT_U32BE: encode = swap32(v[31:0]);
         FMT_ULAW:             encode = {24'd0, ulaw_enc(s)};
         FMT_ALAW:             encode = {24'd0, alaw_enc(s)};
         default:              encode = '0;
      endcase
   endfunction

endpackage

// ===== src/pcmcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCM channel map converter controller
// Accepts samples and sequences the walk over the map entries.
// ----------------------------------------------------------------------------
module pcmcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_frame_last,
   input  logic [2:0]          map_count,
   input  logic                out_busy,
   input  logic                out_take,
   output pcmcm_pkg::cmd_type  cmd
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SUM   = 2'd2;
   localparam logic [1:0] ST_CALC  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] entry_counter_ff, entry_counter_in;
   logic [2:0] n;
   logic       accept;

   assign n = (map_count > 3'(pcmcm_pkg::MAP_ENTRIES)) ?
              3'(pcmcm_pkg::MAP_ENTRIES) : map_count;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      entry_counter_in = entry_counter_ff;
      cmd = '0;
      cmd.store = accept;
      cmd.entry = entry_counter_ff[1:0];
      cmd.last = (entry_counter_ff + 3'd1 == n);
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_frame_last && n != 3'd0) begin
               state_in = ST_FETCH;
               entry_counter_in = '0;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.add = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (!out_busy || out_take) begin
               cmd.compute = 1'b1;
               if (cmd.last) begin
                  state_in = ST_IDLE;
                  entry_counter_in = '0;
               end else begin
                  state_in = ST_FETCH;
                  entry_counter_in = entry_counter_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_counter_ff <= '0;
      end else begin
         state_ff <= state_in;
         entry_counter_ff <= entry_counter_in;
      end
   end
endmodule

// ===== src/pcmcm_dp.sv =====
// ----------------------------------------------------------------------------
// PCM channel map converter datapath
// Frame store, operand decode, sum, encode and the result register.
// ----------------------------------------------------------------------------
module pcmcm_dp (
   input  logic               clock,
   input  logic               reset,
   input  pcmcm_pkg::cmd_type cmd,
   input  logic [2:0]         req_source_channel,
   input  logic [31:0]        req_sample_bits,
   input  logic [3:0]         source_format,
   input  logic [3:0]         dest_format,
   input  logic [63:0]        entry_a,
   input  logic [63:0]        entry_b,
   input  logic [63:0]        entry_c,
   input  logic [63:0]        entry_d,
   input  logic               rsp_stall,
   output logic               out_busy,
   output logic               out_take,
   output logic               rsp_valid,
   output logic [2:0]         rsp_dest_channel,
   output logic [31:0]        rsp_encoded_bits,
   output logic               rsp_run_last
);
   logic [31:0] frame_store_ff [pcmcm_pkg::CHANNELS];
   logic signed [32:0] opa_ff, opb_ff;
   logic [3:0]  op_ff;
   logic [63:0] e;
   logic [31:0] hi;
   logic signed [32:0] va, vb;
   logic signed [33:0] sum_ff;
   logic valid_ff;

   always_comb begin
      case (cmd.entry)
         2'd0:    e = entry_a;
         2'd1:    e = entry_b;
         2'd2:    e = entry_c;
         default: e = entry_d;
      endcase
      hi = e[63:32];
      va = (32'(e[4:2]) < pcmcm_pkg::CHANNELS) ?
           pcmcm_pkg::decode(frame_store_ff[pcmcm_pkg::CH_W'(e[4:2])], source_format) : '0;
      vb = (hi < 32'(pcmcm_pkg::CHANNELS)) ?
           pcmcm_pkg::decode(frame_store_ff[pcmcm_pkg::CH_W'(hi)], source_format) : '0;
      case (e[1:0])
         pcmcm_pkg::OP_LITERAL: begin
            va = '0;
            vb = 33'($signed(hi));
         end
         pcmcm_pkg::OP_ADDK: vb = 33'($signed(hi));
         pcmcm_pkg::OP_ADD:  ;
         default: vb = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcmcm_pkg::CHANNELS; i++) frame_store_ff[i] <= '0;
      end else if (cmd.store && 32'(req_source_channel) < pcmcm_pkg::CHANNELS) begin
         frame_store_ff[pcmcm_pkg::CH_W'(req_source_channel)] <= req_sample_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         opa_ff <= va;
         opb_ff <= vb;
         op_ff <= {cmd.last, e[7:5]};
      end
      if (cmd.add) begin
         sum_ff <= 34'(opa_ff) + 34'(opb_ff);
      end
      if (cmd.compute) begin
         rsp_dest_channel <= op_ff[2:0];
         rsp_run_last <= op_ff[3];
         rsp_encoded_bits <= pcmcm_pkg::encode(sum_ff, dest_format);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.compute) valid_ff <= 1'b1;
      else if (out_take) valid_ff <= 1'b0;
   end

   assign rsp_valid = valid_ff;
   assign out_busy = valid_ff;
   assign out_take = valid_ff && !rsp_stall;
endmodule

// ===== src/pcm_channel_map_converter.sv =====
// ----------------------------------------------------------------------------
// PCM channel map converter
// Stores one frame of raw samples and emits mapped, format-converted results.
// ----------------------------------------------------------------------------
// Each sample transfer is stored raw in its channel slot. A transfer with
// frame_last set also starts the map walk when the entry count is nonzero:
// every active entry passes through operand fetch and decode, the exact sum,
// then encode into the result register, and the input is held stalled until
// the last result has been loaded. The single result register is the limit:
// a stalled result holds the walk. Configuration is written through csr_*,
// by the user only while the block is idle; the block does not enforce this.
module pcm_channel_map_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_source_channel,
   input  logic [31:0] req_sample_bits,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_dest_channel,
   output logic [31:0] rsp_encoded_bits,
   output logic        rsp_run_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [3:0]  src_fmt_ff, dst_fmt_ff;
   logic [2:0]  count_ff;
   logic [63:0] ent_a_ff, ent_b_ff, ent_c_ff, ent_d_ff;
   pcmcm_pkg::cmd_type cmd;
   logic out_busy, out_take;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= pcmcm_pkg::FMT_S16LE;
         dst_fmt_ff <= pcmcm_pkg::FMT_S16LE;
         count_ff <= '0;
         ent_a_ff <= '0;
         ent_b_ff <= '0;
         ent_c_ff <= '0;
         ent_d_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pcmcm_pkg::REG_SRC_FMT: src_fmt_ff <= csr_data[3:0];
            pcmcm_pkg::REG_DST_FMT: dst_fmt_ff <= csr_data[3:0];
            pcmcm_pkg::REG_COUNT:   count_ff <= csr_data[2:0];
            pcmcm_pkg::REG_ENTRY_A: ent_a_ff <= csr_data;
            pcmcm_pkg::REG_ENTRY_B: ent_b_ff <= csr_data;
            pcmcm_pkg::REG_ENTRY_C: ent_c_ff <= csr_data;
            pcmcm_pkg::REG_ENTRY_D: ent_d_ff <= csr_data;
            default: ;
         endcase
      end
   end

   pcmcm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_frame_last,
      .map_count(count_ff), .out_busy, .out_take, .cmd
   );

   pcmcm_dp u_dp (
      .clock, .reset, .cmd, .req_source_channel, .req_sample_bits,
      .source_format(src_fmt_ff), .dest_format(dst_fmt_ff),
      .entry_a(ent_a_ff), .entry_b(ent_b_ff), .entry_c(ent_c_ff), .entry_d(ent_d_ff),
      .rsp_stall, .out_busy, .out_take, .rsp_valid, .rsp_dest_channel,
      .rsp_encoded_bits, .rsp_run_last
   );
endmodule

// ===== src/pcmcm_checker.sv =====
// ----------------------------------------------------------------------------
// PCM channel map converter checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module pcmcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_frame_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_dest_channel,
   input logic [31:0] rsp_encoded_bits,
   input logic        rsp_run_last
);
   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encoded_bits)
      && $stable(rsp_dest_channel) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // A sample that does not end a frame never blocks the next one.
   a_nolast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_frame_last |=> !req_stall)
      else $error("stall after a non-final sample");

   // Nothing comes out right after reset.
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // With the walk over and no new frame end arriving, the input stays open
   // after the last result is taken.
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_run_last && !req_stall
      && !(req_valid && req_frame_last) |=> !req_stall)
      else $error("input still stalled after final result");
endmodule

bind pcm_channel_map_converter pcmcm_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .req_frame_last, .rsp_valid,
   .rsp_stall, .rsp_dest_channel, .rsp_encoded_bits, .rsp_run_last
);
